@@ src/srvp_pkg.sv @@
// ----------------------------------------------------------------------------
// srvp_pkg: shared types and constants of the sine-ramp velocity profile
// Field widths, register indexes, the control bundle of the multiply lanes
// and the elaboration-time builder of the quarter-wave sine table.
// ----------------------------------------------------------------------------
package srvp_pkg;

	// Field widths
	localparam int VEL_W     = 24;
	localparam int TIME_W    = 24;
	localparam int PERIOD_W  = 16;
	localparam int ELAPSED_W = 26;
	localparam int SINE_W    = 15;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_W     = 24;

	// Number of velocity fields on the result word, used or not
	localparam int NUM_AXIS_FIELDS = 6;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_LAST = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP      = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD      = 4'd7;

	localparam logic [TIME_W-1:0] RAMP_RESET = 24'd1000000;

	// pi/2 in Q30
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// Control bundle broadcast to every multiply lane
	typedef struct packed {
		logic load;
		logic step;
		logic sbit;
	} mul_ctl_t;

	// One entry of the quarter-wave table: sin(pi/2 * k / 2^log2n) in Q0.15,
	// from a Q30 Taylor series up to x^13, rounded half up and clamped.
	function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k,
		input int unsigned log2n);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic signed [63:0] scaled;
		x      = (HALF_PI_Q30 * 64'(k)) >> log2n;
		x2     = (x * x) >> 30;
		term   = x;
		sum    = $signed(x);
		term   = ((term * x2) >> 30) / 64'd6;
		sum    = sum - $signed(term);
		term   = ((term * x2) >> 30) / 64'd20;
		sum    = sum + $signed(term);
		term   = ((term * x2) >> 30) / 64'd42;
		sum    = sum - $signed(term);
		term   = ((term * x2) >> 30) / 64'd72;
		sum    = sum + $signed(term);
		term   = ((term * x2) >> 30) / 64'd110;
		sum    = sum - $signed(term);
		term   = ((term * x2) >> 30) / 64'd156;
		sum    = sum + $signed(term);
		if (sum < 0) begin
			sum = 0;
		end
		scaled = (sum * 64'sd32768 + 64'sd536870912) >>> 30;
		if (scaled > 64'sd32767) begin
			scaled = 64'sd32767;
		end
		return scaled[SINE_W-1:0];
	endfunction

endpackage

@@ src/srvp_div.sv @@
// ----------------------------------------------------------------------------
// srvp_div: bit-serial fraction divider
// Gives floor(2^QUOT_W * num / den) for num < den, one quotient bit a cycle
// by restoring division.
// ----------------------------------------------------------------------------
module srvp_div #(
	parameter int QUOT_W = 10
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [srvp_pkg::TIME_W-1:0] num,
	input  logic [srvp_pkg::TIME_W-1:0] den,
	output logic                      done,
	output logic [QUOT_W-1:0]         quot
);
	import srvp_pkg::*;

	localparam int CNT_W = $clog2(QUOT_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TIME_W-1:0] rem_q;
	logic [QUOT_W-1:0] quot_q;
	logic [TIME_W:0]   rem2;
	logic              qbit;

	// Doubled remainder against the divisor
	assign rem2 = {rem_q, 1'b0};
	assign qbit = rem2 >= {1'b0, den};

	// Sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(QUOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= qbit ? TIME_W'(rem2 - {1'b0, den}) : rem2[TIME_W-1:0];
			quot_q <= {quot_q[QUOT_W-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

@@ src/srvp_mul.sv @@
// ----------------------------------------------------------------------------
// srvp_mul: bit-serial velocity scaling lane
// Forms peak * s / 2^15 truncated toward zero, taking one bit of the sine
// value per step, lowest bit first, with a shift-right accumulator.
// ----------------------------------------------------------------------------
module srvp_mul (
	input  logic                            clk,
	input  srvp_pkg::mul_ctl_t              ctl,
	input  logic signed [srvp_pkg::VEL_W-1:0] peak,
	output logic signed [srvp_pkg::VEL_W-1:0] prod
);
	import srvp_pkg::*;

	logic             neg_q;
	logic [VEL_W-1:0] mag_q;
	logic [VEL_W-1:0] acc_q;
	logic [VEL_W:0]   sum;

	// Partial sum of this step; the dropped low bit is the truncation
	assign sum = {1'b0, acc_q} + (ctl.sbit ? {1'b0, mag_q} : '0);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			neg_q <= peak[VEL_W-1];
			mag_q <= peak[VEL_W-1] ? (~peak + 1'b1) : peak;
			acc_q <= '0;
		end else if (ctl.step) begin
			acc_q <= sum[VEL_W:1];
		end
	end

	// Restore the sign on the magnitude
	assign prod = neg_q ? $signed(~acc_q + 1'b1) : $signed(acc_q);

endmodule

@@ src/sine_ramp_velocity_profile.sv @@
// ----------------------------------------------------------------------------
// sine_ramp_velocity_profile: sinusoidal-ramp trapezoid velocity profile
// Accumulates tick periods into a saturating elapsed time and gives up to
// six axis velocities that ramp up and down along a quarter-wave sine.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Word                               Handshake
//  s_*      in         tdata[15:0] tick_period_us         tvalid/tready
//  m_*      out        tdata vel_axis0..5, tuser done     tvalid/tready
//  cfg_*    in         index, 24-bit data                 cfg_wen, no wait
//
// From acceptance to the output register a word passes the states C1, C2, C3
// and DEC; in a ramp phase it then passes the bit-serial divider (DIV), the
// table read (ROM) and the 15 steps of the serial multiply lanes (MUL), while
// hold and ended words go straight to OUT. One word is worked on at a time;
// s_tready is high only when idle, and a finished word may wait in the output
// register while the next is taken. A stalled output holds the next result in
// its last state. Reset clears the elapsed time and loads the register reset
// values. SINE_ENTRIES must be a power of two.
// ----------------------------------------------------------------------------
module sine_ramp_velocity_profile #(
	parameter int SINE_ENTRIES = 1024,
	parameter int AXES         = 6
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Tick input
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [15:0]                        s_tdata,  // [15:0] tick_period_us
	// Velocity output
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [23:0] vel_axis0, [47:24] vel_axis1, [71:48] vel_axis2,
	// [95:72] vel_axis3, [119:96] vel_axis4, [143:120] vel_axis5
	output logic [143:0]                       m_tdata,
	output logic [0:0]                         m_tuser,  // [0] motion_done
	// Configuration
	input  logic                               cfg_wen,
	input  logic [srvp_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [srvp_pkg::CFG_W-1:0]         cfg_wdata
);
	import srvp_pkg::*;

	localparam int LOG2N = $clog2(SINE_ENTRIES);
	localparam int IDX_W = LOG2N + 1;
	localparam int MCNT_W = $clog2(SINE_W);

	// Sequencer states
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_C1   = 4'd1;
	localparam logic [3:0] ST_C2   = 4'd2;
	localparam logic [3:0] ST_C3   = 4'd3;
	localparam logic [3:0] ST_DEC  = 4'd4;
	localparam logic [3:0] ST_DIV  = 4'd5;
	localparam logic [3:0] ST_ROM  = 4'd6;
	localparam logic [3:0] ST_MUL  = 4'd7;
	localparam logic [3:0] ST_OUT  = 4'd8;

	// Profile phases
	localparam logic [1:0] MODE_RAMP = 2'd0;
	localparam logic [1:0] MODE_HOLD = 2'd1;
	localparam logic [1:0] MODE_END  = 2'd2;

	logic [3:0]              state_q;
	logic [1:0]              mode_q;
	logic [ELAPSED_W-1:0]    elapsed_q;
	logic [TIME_W-1:0]       ramp_q;
	logic [TIME_W-1:0]       hold_q;
	logic signed [VEL_W-1:0] peak_q [AXES];
	logic [TIME_W:0]         rh_q;
	logic [ELAPSED_W-1:0]    end_q;
	logic                    lt_r_q;
	logic                    lt_rh_q;
	logic                    lt_end_q;
	logic                    ramp_dn_q;
	logic [TIME_W-1:0]       dividend_q;
	logic [SINE_W-1:0]       sine_q;
	logic [MCNT_W-1:0]       mcnt_q;
	logic                    out_valid_q;
	logic [VEL_W-1:0]        out_vel_q [NUM_AXIS_FIELDS];
	logic                    out_done_q;

	logic                    s_fire;
	logic                    out_free;
	logic [ELAPSED_W:0]      elapsed_sum;
	logic                    div_start;
	logic                    div_done;
	logic [LOG2N-1:0]        quot;
	logic [IDX_W-1:0]        sine_idx;
	logic [SINE_W-1:0]       sine_rom [0:SINE_ENTRIES];
	mul_ctl_t                mul_ctl;
	logic signed [VEL_W-1:0] prod [AXES];
	logic [VEL_W-1:0]        vel_next [NUM_AXIS_FIELDS];

	assign s_tready = (state_q == ST_IDLE);
	assign s_fire   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	// Saturating elapsed-time sum
	assign elapsed_sum = {1'b0, elapsed_q} + (ELAPSED_W + 1)'(s_tdata);

	// Quarter-wave sine table, built at elaboration
	for (genvar k = 0; k <= SINE_ENTRIES; k++) begin : g_rom
		assign sine_rom[k] = sine_entry(k, LOG2N);
	end

	// Table index: counts down from the top of the table on the way down
	assign sine_idx = ramp_dn_q ? (IDX_W'(SINE_ENTRIES) - {1'b0, quot}) : {1'b0, quot};

	assign div_start = (state_q == ST_DEC) && (lt_r_q || (!lt_rh_q && lt_end_q));

	// Configuration registers and elapsed time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			ramp_q    <= RAMP_RESET;
			hold_q    <= '0;
			for (int a = 0; a < AXES; a++) begin
				peak_q[a] <= '0;
			end
		end else begin
			if (cfg_wen && cfg_idx <= REG_HOLD) begin
				elapsed_q <= '0;
				if (cfg_idx == REG_RAMP) begin
					ramp_q <= cfg_wdata;
				end else if (cfg_idx == REG_HOLD) begin
					hold_q <= cfg_wdata;
				end else begin
					for (int a = 0; a < AXES; a++) begin
						if (cfg_idx == CFG_IDX_W'(a)) begin
							peak_q[a] <= $signed(cfg_wdata);
						end
					end
				end
			end else if (s_fire) begin
				elapsed_q <= elapsed_sum[ELAPSED_W] ? '1 : elapsed_sum[ELAPSED_W-1:0];
			end
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= MODE_END;
			mcnt_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						state_q <= ST_C1;
					end
				end
				ST_C1: state_q <= ST_C2;
				ST_C2: state_q <= ST_C3;
				ST_C3: state_q <= ST_DEC;
				ST_DEC: begin
					if (div_start) begin
						mode_q  <= MODE_RAMP;
						state_q <= ST_DIV;
					end else if (lt_rh_q) begin
						mode_q  <= MODE_HOLD;
						state_q <= ST_OUT;
					end else begin
						mode_q  <= MODE_END;
						state_q <= ST_OUT;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_ROM;
					end
				end
				ST_ROM: begin
					mcnt_q  <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					mcnt_q <= mcnt_q + 1'b1;
					if (mcnt_q == MCNT_W'(SINE_W - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Phase boundaries and divider operand
	always_ff @(posedge clk) begin
		case (state_q)
			ST_C1: begin
				lt_r_q <= elapsed_q < ELAPSED_W'(ramp_q);
				rh_q   <= {1'b0, ramp_q} + {1'b0, hold_q};
			end
			ST_C2: begin
				lt_rh_q <= elapsed_q < ELAPSED_W'(rh_q);
				end_q   <= ELAPSED_W'(rh_q) + ELAPSED_W'(ramp_q);
			end
			ST_C3: begin
				lt_end_q   <= elapsed_q < end_q;
				ramp_dn_q  <= !lt_r_q;
				dividend_q <= lt_r_q ? elapsed_q[TIME_W-1:0]
				                     : TIME_W'(elapsed_q - ELAPSED_W'(rh_q));
			end
			ST_ROM:  sine_q <= sine_rom[sine_idx];
			ST_MUL:  sine_q <= sine_q >> 1;
			default: ;
		endcase
	end

	srvp_div #(
		.QUOT_W(LOG2N)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (dividend_q),
		.den    (ramp_q),
		.done   (div_done),
		.quot   (quot)
	);

	// Lane control: load while the table is read, then one bit per step
	assign mul_ctl.load = (state_q == ST_ROM);
	assign mul_ctl.step = (state_q == ST_MUL);
	assign mul_ctl.sbit = sine_q[0];

	for (genvar a = 0; a < AXES; a++) begin : g_lane
		srvp_mul u_mul (
			.clk  (clk),
			.ctl  (mul_ctl),
			.peak (peak_q[a]),
			.prod (prod[a])
		);
	end

	// Velocity selection per phase; unused axes stay zero
	for (genvar a = 0; a < NUM_AXIS_FIELDS; a++) begin : g_sel
		if (a < AXES) begin : g_used
			always_comb begin
				case (mode_q)
					MODE_RAMP: vel_next[a] = prod[a];
					MODE_HOLD: vel_next[a] = peak_q[a];
					default:   vel_next[a] = '0;
				endcase
			end
		end else begin : g_unused
			assign vel_next[a] = '0;
		end
		assign m_tdata[a*VEL_W +: VEL_W] = out_vel_q[a];
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			out_vel_q  <= vel_next;
			out_done_q <= (mode_q == MODE_END);
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tuser[0] = out_done_q;

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the sine-ramp velocity profile
// Sends control ticks in random bursts while the result side stalls on a
// pattern of its own. A scoreboard object keeps its own copy of the profile
// registers, the elapsed time and the quarter-wave table. It predicts the
// velocity word of every accepted tick and compares each returned word with
// the oldest prediction, axis by axis, together with the done flag.
// ----------------------------------------------------------------------------
module tb;

	localparam int SINE_N           = 1024;
	localparam int AXES_USED        = 6;
	localparam int AXIS_FIELDS      = srvp_pkg::NUM_AXIS_FIELDS;
	localparam int VW               = srvp_pkg::VEL_W;
	localparam longint unsigned ELAPSED_MAX = (64'd1 << srvp_pkg::ELAPSED_W) - 64'd1;
	// pi/2 in Q30
	localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
	localparam logic [srvp_pkg::CFG_IDX_W-1:0] REG_PEAK_FIRST = '0;
	localparam logic [srvp_pkg::CFG_IDX_W-1:0] REG_UNUSED_LOW = srvp_pkg::REG_HOLD + 4'd1;
	localparam logic [srvp_pkg::CFG_IDX_W-1:0] REG_UNUSED_TOP = '1;
	localparam int RANDOM_TICKS     = 920;
	localparam int LONG_HOLDOFF     = 300;
	localparam int DRAIN_CYCLES     = 40;
	localparam int CYCLE_LIMIT      = 1000000;

	typedef enum logic [1:0] {SEG_RAMP, SEG_HOLD, SEG_END} segment_e;
	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_ONE_IN_FOUR, RX_RARE_STALL} rx_pattern_e;

	typedef struct packed {
		logic                            done;
		logic [AXIS_FIELDS-1:0][VW-1:0] vel;
	} velocity_word_t;

	// Profile predictor and store of the velocity words still to come
	class velocity_scoreboard;
		logic signed [VW-1:0]                peak [AXIS_FIELDS];
		logic [srvp_pkg::TIME_W-1:0]         ramp_us;
		logic [srvp_pkg::TIME_W-1:0]         hold_us;
		logic [srvp_pkg::ELAPSED_W-1:0]      elapsed_us;
		logic [srvp_pkg::SINE_W-1:0]         sine_q15 [SINE_N+1];
		velocity_word_t                      expected_words [$];
		int unsigned                         errors;

		function new();
			longint unsigned x;
			longint unsigned x2;
			longint unsigned term;
			longint          acc;
			longint          q;
			// Quarter-wave table from a Q30 Taylor series up to the x^13 term
			for (int k = 0; k <= SINE_N; k++) begin
				x    = (QUARTER_TURN_Q30 * 64'(k)) / 64'(SINE_N);
				x2   = (x * x) >> 30;
				term = x;
				acc  = longint'(x);
				for (int n = 1; n <= 6; n++) begin
					term = ((term * x2) >> 30) / 64'(4 * n * n + 2 * n);
					if (n % 2 == 1) begin
						acc = acc - longint'(term);
					end else begin
						acc = acc + longint'(term);
					end
				end
				if (acc < 0) begin
					acc = 0;
				end
				q = (acc * 32768 + 536870912) >>> 30;
				if (q > 32767) begin
					q = 32767;
				end
				sine_q15[k] = q[srvp_pkg::SINE_W-1:0];
			end
			for (int a = 0; a < AXIS_FIELDS; a++) begin
				peak[a] = '0;
			end
			ramp_us    = srvp_pkg::RAMP_RESET;
			hold_us    = '0;
			elapsed_us = '0;
			errors     = 0;
		endfunction

		function int unsigned pending();
			return expected_words.size();
		endfunction

		// A write to a listed register also restarts the profile
		function void note_config(logic [srvp_pkg::CFG_IDX_W-1:0] idx, logic [VW-1:0] value);
			if (idx <= srvp_pkg::REG_PEAK_LAST) begin
				peak[idx] = value;
			end else if (idx == srvp_pkg::REG_RAMP) begin
				ramp_us = value;
			end else if (idx == srvp_pkg::REG_HOLD) begin
				hold_us = value;
			end else begin
				return;
			end
			elapsed_us = '0;
		endfunction

		// Peak times a Q0.15 sine, truncated toward zero
		function logic [VW-1:0] scale_by_sine(logic signed [VW-1:0] pk,
			logic [srvp_pkg::SINE_W-1:0] s);
			longint prod;
			prod = longint'(pk) * longint'(s);
			prod = prod / 32768;
			return prod[VW-1:0];
		endfunction

		function void note_tick(logic [15:0] period);
			longint unsigned t;
			longint unsigned r;
			longint unsigned h;
			longint unsigned idx;
			logic [srvp_pkg::SINE_W-1:0] s;
			segment_e seg;
			velocity_word_t w;
			t = 64'(elapsed_us) + 64'(period);
			if (t > ELAPSED_MAX) begin
				t = ELAPSED_MAX;
			end
			elapsed_us = t[srvp_pkg::ELAPSED_W-1:0];
			r = 64'(ramp_us);
			h = 64'(hold_us);
			s = '0;
			// Work out the phase of the profile and the sine sample
			if (t < r) begin
				idx = (t * SINE_N) / r;
				if (idx > SINE_N) begin
					idx = SINE_N;
				end
				s   = sine_q15[idx];
				seg = SEG_RAMP;
			end else if (t < r + h) begin
				seg = SEG_HOLD;
			end else if (t < 2 * r + h) begin
				idx = ((t - h) * SINE_N) / r;
				if (idx > 2 * SINE_N) begin
					idx = 2 * SINE_N;
				end
				if (idx < SINE_N) begin
					idx = SINE_N;
				end
				s   = sine_q15[2 * SINE_N - idx];
				seg = SEG_RAMP;
			end else begin
				seg = SEG_END;
			end
			w = '0;
			for (int a = 0; a < AXES_USED; a++) begin
				case (seg)
					SEG_RAMP: w.vel[a] = scale_by_sine(peak[a], s);
					SEG_HOLD: w.vel[a] = peak[a];
					default:  w.vel[a] = '0;
				endcase
			end
			w.done = (seg == SEG_END);
			expected_words.push_back(w);
		endfunction

		function void check_word(logic [AXIS_FIELDS*VW-1:0] data, logic done);
			velocity_word_t w;
			if (expected_words.size() == 0) begin
				$display("%0t: velocity word with none expected: tdata=%h done=%b",
					$time, data, done);
				errors++;
				return;
			end
			w = expected_words.pop_front();
			for (int a = 0; a < AXIS_FIELDS; a++) begin
				if (data[a*VW +: VW] !== w.vel[a]) begin
					$display("%0t: vel_axis%0d expected %0d, got %0d", $time, a,
						$signed(w.vel[a]), $signed(data[a*VW +: VW]));
					errors++;
				end
			end
			if (done !== w.done) begin
				$display("%0t: motion_done expected %b, got %b", $time, w.done, done);
				errors++;
			end
		endfunction
	endclass

	logic                                 clk;
	logic                                 arst_n;
	logic                                 s_tvalid;
	logic                                 s_tready;
	logic [15:0]                          s_tdata;    // [15:0] tick_period_us
	logic                                 m_tvalid;
	logic                                 m_tready;
	// [23:0] vel_axis0 ... [143:120] vel_axis5
	logic [AXIS_FIELDS*VW-1:0]            m_tdata;
	logic [0:0]                           m_tuser;    // [0] motion_done
	logic                                 cfg_wen;
	logic [srvp_pkg::CFG_IDX_W-1:0]       cfg_idx;
	logic [srvp_pkg::CFG_W-1:0]           cfg_wdata;

	velocity_scoreboard vel_sb;
	int unsigned        burst_left;
	bit                 rx_hold_req;

	sine_ramp_velocity_profile #(
		.SINE_ENTRIES (SINE_N),
		.AXES         (AXES_USED)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// 100 MHz clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one tick word; a new burst starts after a random gap
	task automatic send_tick(input logic [15:0] period);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
			if (gap != 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= period;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		vel_sb.note_tick(period);
	endtask

	// Stop offering ticks and wait until every predicted word has come back
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (vel_sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [srvp_pkg::CFG_IDX_W-1:0] idx,
		input logic [srvp_pkg::CFG_W-1:0] value);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		vel_sb.note_config(idx, value);
		@(negedge clk);
		cfg_wen   <= 1'b0;
	endtask

	// Random peaks, ramp and hold lengths, extremes included
	task automatic reconfigure();
		logic [srvp_pkg::CFG_W-1:0] value;
		for (int a = 0; a < AXIS_FIELDS; a++) begin
			if ($urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 7))
					0:       value = 24'h7FFFFF;
					1:       value = 24'h800000;
					2:       value = '0;
					3:       value = 24'(int'($urandom_range(0, 512)) - 256);
					default: value = 24'($urandom);
				endcase
				write_reg(REG_PEAK_FIRST + 4'(a), value);
			end
		end
		if ($urandom_range(0, 3) != 0) begin
			case ($urandom_range(0, 15))
				0:             value = '0;
				1:             value = 24'hFFFFFF;
				2, 3, 4:       value = 24'($urandom_range(1, 64));
				5, 6, 7, 8, 9: value = 24'($urandom_range(65, 20000));
				10, 11, 12, 13: value = 24'($urandom_range(20001, 1000000));
				default:       value = 24'($urandom_range(1000001, 24'hFFFFFF));
			endcase
			write_reg(srvp_pkg::REG_RAMP, value);
		end
		if ($urandom_range(0, 2) != 0) begin
			case ($urandom_range(0, 15))
				0, 1, 2, 3, 4, 5: value = '0;
				6, 7, 8, 9, 10:   value = 24'($urandom_range(1, 5000));
				11, 12, 13:       value = 24'($urandom_range(5001, 1000000));
				14:               value = 24'hFFFFFF;
				default:          value = 24'($urandom);
			endcase
			write_reg(srvp_pkg::REG_HOLD, value);
		end
	endtask

	// Result side: stall patterns of random length, and one long hold-off on request
	initial begin : result_sink
		int unsigned seg_left;
		int unsigned beat;
		rx_pattern_e pattern;
		logic        ready_now;
		m_tready = 1'b0;
		seg_left = 0;
		beat     = 0;
		pattern  = RX_OPEN;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLDOFF) @(negedge clk);
				rx_hold_req = 1'b0;
			end
			if (seg_left == 0) begin
				pattern  = rx_pattern_e'($urandom_range(0, 3));
				seg_left = $urandom_range(1, 60);
			end
			seg_left--;
			beat++;
			case (pattern)
				RX_OPEN:        ready_now = 1'b1;
				RX_COIN:        ready_now = 1'($urandom_range(0, 1));
				RX_ONE_IN_FOUR: ready_now = (beat % 4 == 0);
				default:        ready_now = ($urandom_range(0, 7) != 0);
			endcase
			m_tready <= ready_now;
		end
	end

	// Every word that leaves the block is checked against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			vel_sb.check_word(m_tdata, m_tuser[0]);
		end
	end

	// Cycle limit on the whole run
	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("FAIL");
		$finish;
	end

	initial begin : stimulus
		int unsigned ticks_sent;
		int unsigned phase;
		int unsigned n_ticks;
		longint unsigned span;
		longint unsigned pmax;
		logic [15:0] period;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		cfg_wen     = 1'b0;
		cfg_idx     = '0;
		cfg_wdata   = '0;
		arst_n      = 1'b0;
		burst_left  = 0;
		rx_hold_req = 1'b0;
		vel_sb      = new();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: zero peaks, ramp of one second
		send_tick(16'd0);
		send_tick(16'd1);
		settle();

		// Extreme peaks, short ramp and hold; walk through every phase
		write_reg(REG_PEAK_FIRST,         24'h7FFFFF);
		write_reg(REG_PEAK_FIRST + 4'd1,  24'h800000);
		write_reg(REG_PEAK_FIRST + 4'd2,  24'hFFFFFF);
		write_reg(REG_PEAK_FIRST + 4'd3,  24'h000001);
		write_reg(REG_PEAK_FIRST + 4'd4,  24'h000000);
		write_reg(srvp_pkg::REG_PEAK_LAST, 24'hA5C3E1);
		write_reg(srvp_pkg::REG_RAMP, 24'd1000);
		write_reg(srvp_pkg::REG_HOLD, 24'd500);
		send_tick(16'd0);
		send_tick(16'd1);
		send_tick(16'd250);
		send_tick(16'd249);
		send_tick(16'd499);
		send_tick(16'd1);
		send_tick(16'd499);
		send_tick(16'd1);
		send_tick(16'd500);
		send_tick(16'd499);
		send_tick(16'd1);
		send_tick(16'hFFFF);
		settle();

		// Writes beyond the register list leave the elapsed time alone
		write_reg(REG_UNUSED_LOW, 24'h000000);
		write_reg(REG_UNUSED_TOP, 24'hFFFFFF);
		send_tick(16'd0);
		settle();

		// Zero ramp time: straight into the hold, then the end
		write_reg(srvp_pkg::REG_RAMP, 24'd0);
		send_tick(16'd0);
		send_tick(16'd499);
		send_tick(16'd1);
		settle();

		// Longest ramp and hold
		write_reg(srvp_pkg::REG_RAMP, 24'hFFFFFF);
		write_reg(srvp_pkg::REG_HOLD, 24'hFFFFFF);
		send_tick(16'hFFFF);
		send_tick(16'hFFFF);

		// Random profiles sized so that most runs pass through every phase
		ticks_sent = 0;
		phase      = 0;
		while (ticks_sent < RANDOM_TICKS) begin
			settle();
			if ($urandom_range(0, 3) != 0) begin
				reconfigure();
			end
			if ($urandom_range(0, 7) == 0) begin
				write_reg(4'($urandom_range(REG_UNUSED_LOW, REG_UNUSED_TOP)), 24'($urandom));
			end
			// The result side holds off for a long stretch while ticks keep coming
			if (phase == 3) begin
				rx_hold_req = 1'b1;
			end
			n_ticks = $urandom_range(20, 70);
			span    = 2 * 64'(vel_sb.ramp_us) + 64'(vel_sb.hold_us);
			pmax    = (span * 5) / (2 * n_ticks) + 1;
			if (pmax > 65535) begin
				pmax = 65535;
			end
			repeat (n_ticks) begin
				if ($urandom_range(0, 15) == 0) begin
					period = 16'($urandom);
				end else begin
					period = 16'($urandom_range(0, 32'(pmax)));
				end
				send_tick(period);
				ticks_sent++;
			end
			phase++;
		end

		// A short profile, then ticks that run well past its end
		settle();
		write_reg(srvp_pkg::REG_RAMP, 24'($urandom_range(1, 5000)));
		write_reg(srvp_pkg::REG_HOLD, 24'($urandom_range(0, 5000)));
		repeat (10) send_tick(16'($urandom));

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (vel_sb.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
